### hdl/cbvd_pkg.sv
// Shared types and codes for the cell-block video decoder.
// Used by cbvd_ctrl, cbvd_dp and cell_block_video_decoder; depends on nothing.
`timescale 1ns / 1ps

package cbvd_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);

    // Input item functions.
    localparam logic [1:0] FUNC_BYTE   = 2'd0;
    localparam logic [1:0] FUNC_LUMA   = 2'd1;
    localparam logic [1:0] FUNC_CHROMA = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_ROW    = 2'd0;
    localparam logic [1:0] KIND_SIZE   = 2'd1;
    localparam logic [1:0] KIND_REGION = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // Packet parser phases.
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_BODY   = 2'd1;
    localparam logic [1:0] PH_BOTTOM = 2'd2;
    localparam logic [1:0] PH_DRAIN  = 2'd3;

    localparam logic [7:0] SKIP_MIN = 8'd128;
    localparam logic [7:0] SKIP_BIAS = 8'd127;

    // What an accepted item leaves to do.
    typedef struct packed {
        logic size;
        logic err;
        logic pixels;
        logic skip;
        logic region;
    } cbvd_work_t;

    typedef struct packed {
        logic       accept;
        logic       emit_size;
        logic       emit_err;
        logic       emit_row;
        logic [1:0] row;
        logic       emit_region;
        logic       last;
        logic       skip_step;
        logic       fin_cell;
    } cbvd_cmd_t;

    typedef struct packed {
        cbvd_work_t work;
        logic       out_free;
        logic       skip_done;
    } cbvd_status_t;

endpackage

### hdl/cbvd_ctrl.sv
// Controller of the cell-block video decoder: sequences the results of one item.
// Depends on cbvd_pkg.
`timescale 1ns / 1ps

module cbvd_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  cbvd_pkg::cbvd_status_t status,
    output cbvd_pkg::cbvd_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                 state_reg, state_next;
    cbvd_pkg::cbvd_work_t work_reg, work_next;
    logic                 fin_reg, fin_next;
    logic [1:0]           row_reg, row_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        work_next  = work_reg;
        fin_next   = fin_reg;
        row_next   = row_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    work_next  = status.work;
                    fin_next   = 1'b0;
                    row_next   = 2'd0;
                    state_next = ST_RUN;
                end
            end
            default: begin
                priority if (work_reg.size) begin
                    if (status.out_free) begin
                        cmd.emit_size  = 1'b1;
                        cmd.last       = !(work_reg.err || work_reg.region);
                        work_next.size = 1'b0;
                    end
                end else if (work_reg.err) begin
                    if (status.out_free) begin
                        cmd.emit_err  = 1'b1;
                        cmd.last      = 1'b1;
                        work_next.err = 1'b0;
                    end
                end else if (work_reg.pixels) begin
                    if (status.out_free) begin
                        cmd.emit_row = 1'b1;
                        cmd.row      = row_reg;
                        cmd.last     = (row_reg == 2'd3) && !work_reg.region;
                        row_next     = row_reg + 2'd1;
                        if (row_reg == 2'd3) begin
                            work_next.pixels = 1'b0;
                            fin_next         = 1'b1;
                        end
                    end
                end else if (fin_reg) begin
                    cmd.fin_cell = 1'b1;
                    fin_next     = 1'b0;
                end else if (work_reg.skip) begin
                    cmd.skip_step = 1'b1;
                    if (status.skip_done) begin
                        work_next.skip = 1'b0;
                    end
                end else if (work_reg.region) begin
                    if (status.out_free) begin
                        cmd.emit_region  = 1'b1;
                        cmd.last         = 1'b1;
                        work_next.region = 1'b0;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            work_reg  <= '0;
            fin_reg   <= 1'b0;
            row_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            work_reg  <= work_next;
            fin_reg   <= fin_next;
            row_reg   <= row_next;
        end
    end

endmodule

### hdl/cbvd_dp.sv
// Datapath of the cell-block video decoder: parser state, pair tables, skip
// unit and the result register. Depends on cbvd_pkg; driven by cbvd_ctrl.
`timescale 1ns / 1ps

module cbvd_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cbvd_pkg::cbvd_cmd_t    cmd,
    output cbvd_pkg::cbvd_status_t status,
    input  logic [1:0]             s_func,
    input  logic [7:0]             s_packet_byte,
    input  logic                   s_end_of_packet,
    input  logic [7:0]             s_table_index,
    input  logic [15:0]            s_table_word,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_kind,
    output logic [15:0]            m_pixel_row,
    output logic [13:0]            m_cell_column,
    output logic [7:0]             m_luma0,
    output logic [7:0]             m_luma1,
    output logic [7:0]             m_luma2,
    output logic [7:0]             m_luma3,
    output logic [7:0]             m_chroma_u,
    output logic [7:0]             m_chroma_v,
    output logic [15:0]            m_extent_a,
    output logic [15:0]            m_extent_b,
    output logic                   m_last
);

    logic [15:0] luma_mem   [cbvd_pkg::TABLE_ENTRIES];
    logic [15:0] chroma_mem [cbvd_pkg::TABLE_ENTRIES];
    logic [15:0] yy_reg, uv_reg, mask_reg;

    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  bc_reg, bc_next;
    logic [55:0] hdr_reg, hdr_next;
    logic [23:0] code_reg, code_next;
    logic [13:0] cx_reg, cx_next;
    logic [13:0] cy_reg, cy_next;
    logic [13:0] start_reg, start_next;
    logic [13:0] wc_reg, wc_next;
    logic [13:0] hc_reg, hc_next;
    logic [15:0] sw_reg, sw_next;
    logic [15:0] sh_reg, sh_next;
    logic [14:0] skx_reg, skx_next;
    logic        eop_reg, eop_next;

    logic [15:0] hw, hh, hx, hy;
    logic [14:0] cell_nx, cell_ny;
    logic [14:0] rows;
    logic        skip_done;

    cbvd_pkg::cbvd_work_t work;

    // Header fields as they stand once the eighth byte arrives.
    assign hx = hdr_reg[55:40];
    assign hy = hdr_reg[39:24];
    assign hw = hdr_reg[23:8];
    assign hh = {hdr_reg[7:0], s_packet_byte};

    assign cell_nx   = {1'b0, cx_reg} + 15'd1;
    assign skip_done = (cy_reg >= hc_reg) || (skx_reg < {1'b0, wc_reg});
    assign rows      = {1'b0, cy_reg} - {1'b0, start_reg}
                       + {14'd0, (cx_reg != 14'd0)};

    always_comb begin
        phase_next = phase_reg;
        bc_next    = bc_reg;
        hdr_next   = hdr_reg;
        code_next  = code_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        start_next = start_reg;
        wc_next    = wc_reg;
        hc_next    = hc_reg;
        sw_next    = sw_reg;
        sh_next    = sh_reg;
        skx_next   = skx_reg;
        eop_next   = eop_reg;
        work       = '0;
        cell_ny    = {1'b0, cy_reg};

        if (cmd.accept && s_func == cbvd_pkg::FUNC_BYTE) begin
            eop_next = s_end_of_packet;
            unique case (phase_reg)
                cbvd_pkg::PH_HEADER: begin
                    if (bc_reg == 3'd7) begin
                        bc_next = 3'd0;
                        if (hw != sw_reg || hh != sh_reg) begin
                            work.size = 1'b1;
                            sw_next   = hw;
                            sh_next   = hh;
                        end
                        wc_next = hw[15:2];
                        hc_next = hh[15:2];
                        if (hx >= {2'b00, hw[15:2]} || hy >= {2'b00, hh[15:2]}) begin
                            work.err   = 1'b1;
                            phase_next = cbvd_pkg::PH_DRAIN;
                        end else begin
                            cx_next    = hx[13:0];
                            cy_next    = hy[13:0];
                            start_next = hy[13:0];
                            code_next  = '0;
                            phase_next = cbvd_pkg::PH_BODY;
                            work.region = s_end_of_packet;
                        end
                        if (s_end_of_packet) begin
                            phase_next = cbvd_pkg::PH_HEADER;
                            hdr_next   = '0;
                            code_next  = '0;
                        end
                    end else begin
                        hdr_next = {hdr_reg[47:0], s_packet_byte};
                        bc_next  = bc_reg + 3'd1;
                        if (s_end_of_packet) begin
                            work.err   = 1'b1;
                            phase_next = cbvd_pkg::PH_HEADER;
                            bc_next    = 3'd0;
                            hdr_next   = '0;
                            code_next  = '0;
                        end
                    end
                end
                cbvd_pkg::PH_BODY: begin
                    if (bc_reg == 3'd0 && s_packet_byte >= cbvd_pkg::SKIP_MIN) begin
                        work.region = s_end_of_packet;
                        if (wc_reg == 14'd0) begin
                            cx_next    = 14'd0;
                            cy_next    = hc_reg;
                            phase_next = cbvd_pkg::PH_BOTTOM;
                            if (s_end_of_packet) begin
                                phase_next = cbvd_pkg::PH_HEADER;
                                hdr_next   = '0;
                                code_next  = '0;
                            end
                        end else begin
                            work.skip = 1'b1;
                            skx_next  = {1'b0, cx_reg}
                                        + {7'd0, s_packet_byte - cbvd_pkg::SKIP_BIAS};
                        end
                    end else if (bc_reg < 3'd3) begin
                        code_next = {code_reg[15:0], s_packet_byte};
                        bc_next   = bc_reg + 3'd1;
                        if (s_end_of_packet) begin
                            work.err   = 1'b1;
                            phase_next = cbvd_pkg::PH_HEADER;
                            bc_next    = 3'd0;
                            hdr_next   = '0;
                            code_next  = '0;
                        end
                    end else begin
                        // The pair tables are read on this transfer; the
                        // position advances after the four rows go out.
                        work.pixels = 1'b1;
                        work.region = s_end_of_packet;
                        bc_next     = 3'd0;
                        code_next   = '0;
                    end
                end
                cbvd_pkg::PH_BOTTOM: begin
                    if (s_end_of_packet) begin
                        work.region = 1'b1;
                        phase_next  = cbvd_pkg::PH_HEADER;
                        hdr_next    = '0;
                        code_next   = '0;
                    end
                end
                default: begin
                    if (s_end_of_packet) begin
                        phase_next = cbvd_pkg::PH_HEADER;
                        hdr_next   = '0;
                        code_next  = '0;
                    end
                end
            endcase
        end

        if (cmd.fin_cell) begin
            if (cell_nx >= {1'b0, wc_reg}) begin
                cx_next = 14'd0;
                cell_ny = {1'b0, cy_reg} + 15'd1;
            end else begin
                cx_next = cell_nx[13:0];
            end
            if (cell_ny >= {1'b0, hc_reg}) begin
                cx_next    = 14'd0;
                cy_next    = hc_reg;
                phase_next = cbvd_pkg::PH_BOTTOM;
            end else begin
                cy_next = cell_ny[13:0];
            end
            if (eop_reg) begin
                phase_next = cbvd_pkg::PH_HEADER;
                hdr_next   = '0;
            end
        end

        // One subtraction of the width per cycle; stops at the bottom row.
        if (cmd.skip_step) begin
            if (skip_done) begin
                if (cy_reg >= hc_reg) begin
                    cx_next    = 14'd0;
                    cy_next    = hc_reg;
                    phase_next = cbvd_pkg::PH_BOTTOM;
                end else begin
                    cx_next = skx_reg[13:0];
                end
                if (eop_reg) begin
                    phase_next = cbvd_pkg::PH_HEADER;
                    hdr_next   = '0;
                end
            end else begin
                skx_next = skx_reg - {1'b0, wc_reg};
                cy_next  = cy_reg + 14'd1;
            end
        end
    end

    assign status = '{work: work, out_free: (!m_valid || m_ready), skip_done: skip_done};

    always_ff @(posedge aclk) begin
        if (cmd.accept && s_func == cbvd_pkg::FUNC_LUMA) begin
            luma_mem[s_table_index] <= s_table_word;
        end
        if (cmd.accept && s_func == cbvd_pkg::FUNC_CHROMA) begin
            chroma_mem[s_table_index] <= s_table_word;
        end
        if (cmd.accept) begin
            yy_reg   <= luma_mem[s_packet_byte];
            uv_reg   <= chroma_mem[code_reg[7:0]];
            mask_reg <= code_reg[23:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= cbvd_pkg::PH_HEADER;
            bc_reg    <= '0;
            hdr_reg   <= '0;
            code_reg  <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            start_reg <= '0;
            wc_reg    <= '0;
            hc_reg    <= '0;
            sw_reg    <= '0;
            sh_reg    <= '0;
            skx_reg   <= '0;
            eop_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            bc_reg    <= bc_next;
            hdr_reg   <= hdr_next;
            code_reg  <= code_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            start_reg <= start_next;
            wc_reg    <= wc_next;
            hc_reg    <= hc_next;
            sw_reg    <= sw_next;
            sh_reg    <= sh_next;
            skx_reg   <= skx_next;
            eop_reg   <= eop_next;
        end
    end

    // Result register.
    logic [3:0] nib;
    logic       load;

    assign nib  = mask_reg[4'd15 - {cmd.row, 2'b00} -: 4];
    assign load = cmd.emit_size || cmd.emit_err || cmd.emit_row || cmd.emit_region;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_kind        <= cbvd_pkg::KIND_ERROR;
            m_pixel_row   <= '0;
            m_cell_column <= '0;
            m_luma0       <= '0;
            m_luma1       <= '0;
            m_luma2       <= '0;
            m_luma3       <= '0;
            m_chroma_u    <= '0;
            m_chroma_v    <= '0;
            m_extent_a    <= '0;
            m_extent_b    <= '0;
            m_last        <= cmd.last;
            if (cmd.emit_size) begin
                m_kind     <= cbvd_pkg::KIND_SIZE;
                m_extent_a <= sw_reg;
                m_extent_b <= sh_reg;
            end
            if (cmd.emit_row) begin
                m_kind        <= cbvd_pkg::KIND_ROW;
                m_pixel_row   <= {cy_reg, cmd.row};
                m_cell_column <= cx_reg;
                m_luma0       <= nib[3] ? yy_reg[7:0] : yy_reg[15:8];
                m_luma1       <= nib[2] ? yy_reg[7:0] : yy_reg[15:8];
                m_luma2       <= nib[1] ? yy_reg[7:0] : yy_reg[15:8];
                m_luma3       <= nib[0] ? yy_reg[7:0] : yy_reg[15:8];
                m_chroma_u    <= uv_reg[15:8];
                m_chroma_v    <= uv_reg[7:0];
            end
            if (cmd.emit_region) begin
                m_kind      <= cbvd_pkg::KIND_REGION;
                m_pixel_row <= {start_reg, 2'b00};
                m_extent_a  <= {wc_reg, 2'b00};
                m_extent_b  <= {rows[13:0], 2'b00};
            end
        end
    end

endmodule

### hdl/cell_block_video_decoder.sv
// Cell-block video decoder: one input channel (packet bytes and table writes),
// one result channel (pixel rows, size change, region, packet error).
// Usage: feed s_func/s_packet_byte/... with s_valid/s_ready; results leave on
// m_valid/m_ready, m_last marking the final result caused by an input transfer.
// The block takes one input item at a time. A code's final byte yields four
// pixel rows, one per cycle while the receiver does not stall, after the pair
// tables are read on the byte's transfer. A skip byte runs a subtract loop,
// one subtraction per wrapped row; that loop sets the worst case.
// Results go through a single output register; when the receiver stalls, the
// block holds its work and accepts no new item until its results have entered
// the output register.
// Reset (aresetn low, synchronous) returns the parser to the header phase and
// clears position and stored size; pair table contents are undefined until
// written and are not cleared. No clearing pass runs after reset.
// Depends on cbvd_pkg, cbvd_ctrl and cbvd_dp.
`timescale 1ns / 1ps

module cell_block_video_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [7:0]  s_packet_byte,
    input  logic        s_end_of_packet,
    input  logic [7:0]  s_table_index,
    input  logic [15:0] s_table_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [15:0] m_pixel_row,
    output logic [13:0] m_cell_column,
    output logic [7:0]  m_luma0,
    output logic [7:0]  m_luma1,
    output logic [7:0]  m_luma2,
    output logic [7:0]  m_luma3,
    output logic [7:0]  m_chroma_u,
    output logic [7:0]  m_chroma_v,
    output logic [15:0] m_extent_a,
    output logic [15:0] m_extent_b,
    output logic        m_last
);

    cbvd_pkg::cbvd_cmd_t    cmd;
    cbvd_pkg::cbvd_status_t status;

    cbvd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cbvd_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_func          (s_func),
        .s_packet_byte   (s_packet_byte),
        .s_end_of_packet (s_end_of_packet),
        .s_table_index   (s_table_index),
        .s_table_word    (s_table_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_pixel_row     (m_pixel_row),
        .m_cell_column   (m_cell_column),
        .m_luma0         (m_luma0),
        .m_luma1         (m_luma1),
        .m_luma2         (m_luma2),
        .m_luma3         (m_luma3),
        .m_chroma_u      (m_chroma_u),
        .m_chroma_v      (m_chroma_v),
        .m_extent_a      (m_extent_a),
        .m_extent_b      (m_extent_b),
        .m_last          (m_last)
    );

endmodule

### bench/cell_block_video_decoder_test.sv
// Self-checking bench for cell_block_video_decoder: table preload, directed rows,
// then random packets, all checked against a predictor of the decoder.
// Depends on cbvd_pkg and the cell_block_video_decoder RTL.
`timescale 1ns / 1ps

module cell_block_video_decoder_test;

    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_ITEMS = 240;
    localparam int HOLD_CYCLES  = 400;
    localparam int USED_ENTRIES = 16;

    typedef struct {
        logic [1:0]  func;
        logic [7:0]  pbyte;
        logic        eop;
        logic [7:0]  idx;
        logic [15:0] word;
        bit          chk;
        logic [1:0]  chk_kind;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] row;
        logic [13:0] col;
        logic [7:0]  l0, l1, l2, l3, u, v;
        logic [15:0] ea, eb;
        logic        last;
    } res_t;

    logic        aclk, aresetn;
    logic        s_valid, s_ready, s_end_of_packet;
    logic [1:0]  s_func;
    logic [7:0]  s_packet_byte, s_table_index;
    logic [15:0] s_table_word;
    logic        m_valid, m_ready, m_last;
    logic [1:0]  m_kind;
    logic [15:0] m_pixel_row, m_extent_a, m_extent_b;
    logic [13:0] m_cell_column;
    logic [7:0]  m_luma0, m_luma1, m_luma2, m_luma3, m_chroma_u, m_chroma_v;

    cell_block_video_decoder u_top (.*);

    // Predictor state.
    logic [15:0] luma_tab [cbvd_pkg::TABLE_ENTRIES];
    logic [15:0] chroma_tab [cbvd_pkg::TABLE_ENTRIES];
    logic [1:0]  phase;
    int unsigned hdr_cnt;
    logic [63:0] hdr;
    logic [23:0] code;
    int unsigned cx, cy, start_y, w_cells, h_cells, size_w, size_h;

    item_t stim_q[$];
    res_t  pending_q[$];
    int    errors = 0;
    int    accepted = 0;
    int    idle = 0;
    bit    hold_done = 0;

    function automatic res_t mkres(logic [1:0] k, int unsigned r, int unsigned c,
                                   int unsigned a, int unsigned b);
        res_t x;
        x = '0;
        x.kind = k;
        x.row = r[15:0];
        x.col = c[13:0];
        x.ea = a[15:0];
        x.eb = b[15:0];
        return x;
    endfunction

    function automatic res_t region_res();
        int unsigned rows;
        rows = (cx == 0) ? cy - start_y : cy + 1 - start_y;
        return mkres(cbvd_pkg::KIND_REGION, start_y * 4, 0, w_cells * 4, rows * 4);
    endfunction

    function automatic void packet_reset();
        phase = cbvd_pkg::PH_HEADER;
        hdr_cnt = 0;
        hdr = '0;
        code = '0;
    endfunction

    function automatic void clamp_bottom();
        if (cy >= h_cells) begin
            cx = 0;
            cy = h_cells;
            phase = cbvd_pkg::PH_BOTTOM;
        end
    endfunction

    // Updates the decoder state for one transfer; returns how many results it caused.
    function automatic int decode_item(item_t it, output logic [1:0] last_kind);
        res_t out[$];
        int unsigned hx, hy, hw, hh, x, y;
        logic [15:0] yy, uv, mask;
        res_t r;
        if (it.func == cbvd_pkg::FUNC_LUMA) begin
            luma_tab[it.idx] = it.word;
            return 0;
        end
        if (it.func == cbvd_pkg::FUNC_CHROMA) begin
            chroma_tab[it.idx] = it.word;
            return 0;
        end
        if (it.func != cbvd_pkg::FUNC_BYTE) return 0;
        case (phase)
            cbvd_pkg::PH_HEADER: begin
                hdr = {hdr[55:0], it.pbyte};
                if (hdr_cnt == 7) begin
                    hx = hdr[63:48];
                    hy = hdr[47:32];
                    hw = hdr[31:16];
                    hh = hdr[15:0];
                    hdr_cnt = 0;
                    if (hw != size_w || hh != size_h) begin
                        size_w = hw;
                        size_h = hh;
                        out.push_back(mkres(cbvd_pkg::KIND_SIZE, 0, 0, hw, hh));
                    end
                    w_cells = hw >> 2;
                    h_cells = hh >> 2;
                    if (hx >= w_cells || hy >= h_cells) begin
                        out.push_back(mkres(cbvd_pkg::KIND_ERROR, 0, 0, 0, 0));
                        phase = cbvd_pkg::PH_DRAIN;
                    end else begin
                        cx = hx;
                        cy = hy;
                        start_y = hy;
                        code = '0;
                        phase = cbvd_pkg::PH_BODY;
                    end
                    if (it.eop) begin
                        if (phase == cbvd_pkg::PH_BODY) out.push_back(region_res());
                        packet_reset();
                    end
                end else begin
                    hdr_cnt++;
                    if (it.eop) begin
                        out.push_back(mkres(cbvd_pkg::KIND_ERROR, 0, 0, 0, 0));
                        packet_reset();
                    end
                end
            end
            cbvd_pkg::PH_BODY: begin
                if (hdr_cnt == 0 && it.pbyte >= cbvd_pkg::SKIP_MIN) begin
                    if (w_cells == 0) begin
                        cy = h_cells;
                    end else begin
                        x = cx + (it.pbyte - cbvd_pkg::SKIP_BIAS);
                        y = cy + x / w_cells;
                        cx = x % w_cells;
                        cy = (y > h_cells) ? h_cells : y;
                    end
                    clamp_bottom();
                    if (it.eop) begin
                        out.push_back(region_res());
                        packet_reset();
                    end
                end else if (hdr_cnt < 3) begin
                    code = {code[15:0], it.pbyte};
                    hdr_cnt++;
                    if (it.eop) begin
                        out.push_back(mkres(cbvd_pkg::KIND_ERROR, 0, 0, 0, 0));
                        packet_reset();
                    end
                end else begin
                    mask = code[23:8];
                    yy = luma_tab[it.pbyte];
                    uv = chroma_tab[code[7:0]];
                    for (int i = 0; i < 4; i++) begin
                        r = mkres(cbvd_pkg::KIND_ROW, cy * 4 + i, cx, 0, 0);
                        r.l0 = mask[15 - 4 * i] ? yy[7:0] : yy[15:8];
                        r.l1 = mask[14 - 4 * i] ? yy[7:0] : yy[15:8];
                        r.l2 = mask[13 - 4 * i] ? yy[7:0] : yy[15:8];
                        r.l3 = mask[12 - 4 * i] ? yy[7:0] : yy[15:8];
                        r.u = uv[15:8];
                        r.v = uv[7:0];
                        out.push_back(r);
                    end
                    hdr_cnt = 0;
                    code = '0;
                    cx++;
                    if (cx >= w_cells) begin
                        cx = 0;
                        cy++;
                    end
                    clamp_bottom();
                    if (it.eop) begin
                        out.push_back(region_res());
                        packet_reset();
                    end
                end
            end
            cbvd_pkg::PH_BOTTOM: begin
                if (it.eop) begin
                    out.push_back(region_res());
                    packet_reset();
                end
            end
            default: begin
                if (it.eop) packet_reset();
            end
        endcase
        if (out.size() > 0) begin
            out[out.size() - 1].last = 1'b1;
            last_kind = out[out.size() - 1].kind;
        end
        foreach (out[i]) pending_q.push_back(out[i]);
        return out.size();
    endfunction

    function automatic item_t mk(logic [1:0] f, logic [7:0] b, logic e, logic [7:0] ix,
                                 logic [15:0] wd, bit c, logic [1:0] ck);
        item_t it;
        it = '{f, b, e, ix, wd, c, ck};
        return it;
    endfunction

    function automatic void add_bytes(logic [7:0] bytes[$], int cut);
        for (int i = 0; i < bytes.size() && i <= cut; i++) begin
            if ($urandom_range(0, 19) == 0)
                stim_q.push_back(mk(2'($urandom_range(1, 3)), 8'($urandom), 1'($urandom),
                                    8'($urandom), 16'($urandom), 1'b0,
                                    cbvd_pkg::KIND_ROW));
            stim_q.push_back(mk(cbvd_pkg::FUNC_BYTE, bytes[i],
                                (i == cut) || (i == bytes.size() - 1),
                                8'($urandom), 16'($urandom), 1'b0, cbvd_pkg::KIND_ROW));
        end
    endfunction

    function automatic void build_stimulus();
        logic [7:0] b[$];
        int unsigned w, h, sx, sy, n;
        int count;
        // Codes only reference the low table entries and entry 255, so those are
        // written first and no code ever reads a blank entry.
        for (int i = 0; i < USED_ENTRIES; i++) begin
            stim_q.push_back(mk(cbvd_pkg::FUNC_LUMA, 8'($urandom), 1'($urandom), 8'(i),
                                16'($urandom), 1'b0, cbvd_pkg::KIND_ROW));
            stim_q.push_back(mk(cbvd_pkg::FUNC_CHROMA, 8'($urandom), 1'($urandom), 8'(i),
                                16'($urandom), 1'b0, cbvd_pkg::KIND_ROW));
        end
        stim_q.push_back(mk(cbvd_pkg::FUNC_CHROMA, 8'h00, 1'b0, 8'hff, 16'($urandom),
                            1'b0, cbvd_pkg::KIND_ROW));
        // Directed rows; the expected kind is typed in where it is obvious.
        stim_q.push_back(mk(2'd3, 8'hff, 1'b1, 8'hff, 16'hffff, 1'b0, cbvd_pkg::KIND_ROW));
        stim_q.push_back(mk(cbvd_pkg::FUNC_LUMA, 8'h00, 1'b1, 8'hff, 16'h00ff, 1'b0,
                            cbvd_pkg::KIND_ROW));
        for (int i = 0; i < 7; i++)
            stim_q.push_back(mk(cbvd_pkg::FUNC_BYTE, 8'h00, 1'b0, 8'h00, 16'h0000, 1'b0,
                                cbvd_pkg::KIND_ROW));
        stim_q.push_back(mk(cbvd_pkg::FUNC_BYTE, 8'h00, 1'b1, 8'h00, 16'h0000, 1'b1,
                            cbvd_pkg::KIND_ERROR));
        stim_q.push_back(mk(cbvd_pkg::FUNC_BYTE, 8'hff, 1'b0, 8'h00, 16'h0000, 1'b0,
                            cbvd_pkg::KIND_ROW));
        stim_q.push_back(mk(cbvd_pkg::FUNC_BYTE, 8'hff, 1'b1, 8'h00, 16'h0000, 1'b1,
                            cbvd_pkg::KIND_ERROR));
        b = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h10, 8'h00, 8'h08,
              8'h7f, 8'hff, 8'h00, 8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 8'hff, 8'h80};
        add_bytes(b, b.size() - 1);
        // Random packets, mostly well formed.
        count = 0;
        while (count < RANDOM_ITEMS) begin
            b.delete();
            case ($urandom_range(0, 9))
                0: w = $urandom_range(0, 3);
                1: w = 16'hffff;
                default: w = $urandom_range(1, 12) * 4 + $urandom_range(0, 3);
            endcase
            h = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 10) * 4
                + $urandom_range(0, 3);
            h = h & 16'hffff;
            if ($urandom_range(0, 9) == 0) begin
                sx = $urandom & 16'hffff;
                sy = $urandom & 16'hffff;
            end else begin
                sx = (w >= 4) ? $urandom_range(0, w / 4 - 1) : 0;
                sy = (h >= 4) ? $urandom_range(0, (h / 4 - 1 < 20) ? h / 4 - 1 : 20) : 0;
            end
            b = '{sx[15:8], sx[7:0], sy[15:8], sy[7:0], w[15:8], w[7:0], h[15:8], h[7:0]};
            n = $urandom_range(0, 8);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    b.push_back(8'h80 | 8'($urandom));
                end else begin
                    b.push_back(8'($urandom_range(0, 127)));
                    b.push_back(8'($urandom));
                    b.push_back(8'($urandom_range(0, USED_ENTRIES - 1)));
                    b.push_back(8'($urandom_range(0, USED_ENTRIES - 1)));
                end
            end
            if ($urandom_range(0, 7) == 0) b.push_back(8'($urandom));
            add_bytes(b, ($urandom_range(0, 7) == 0) ? $urandom_range(0, b.size() - 1)
                                                      : b.size() - 1);
            count += b.size();
        end
    endfunction

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Check of each transfer on both channels, plus the no-progress watchdog.
    always @(posedge aclk) begin
        res_t got, want;
        logic [1:0] lk;
        int n;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle <= 0;
            else idle <= idle + 1;
            if (idle >= IDLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
            if (s_valid && s_ready) begin
                accepted <= accepted + 1;
                n = decode_item(mk(s_func, s_packet_byte, s_end_of_packet, s_table_index,
                                   s_table_word, 1'b0, cbvd_pkg::KIND_ROW), lk);
                if (stim_q.size() > 0 && stim_q[0].chk && (n == 0 || lk != stim_q[0].chk_kind))
                begin
                    errors++;
                    if (errors <= 10)
                        $display("directed row: expected kind %0d, got kind %0d (%0d results)",
                                 stim_q[0].chk_kind, lk, n);
                end
                if (stim_q.size() > 0) void'(stim_q.pop_front());
            end
            if (m_valid && m_ready) begin
                got = '{m_kind, m_pixel_row, m_cell_column, m_luma0, m_luma1, m_luma2,
                        m_luma3, m_chroma_u, m_chroma_v, m_extent_a, m_extent_b, m_last};
                if (pending_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result kind %0d", m_kind);
                end else begin
                    want = pending_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch exp k%0d r%0d c%0d y%h%h%h%h uv%h%h a%0d b%0d l%0d",
                                want.kind, want.row, want.col, want.l0, want.l1, want.l2,
                                want.l3, want.u, want.v, want.ea, want.eb, want.last,
                                " / got k%0d r%0d c%0d y%h%h%h%h uv%h%h a%0d b%0d l%0d",
                                got.kind, got.row, got.col, got.l0, got.l1, got.l2,
                                got.l3, got.u, got.v, got.ea, got.eb, got.last);
                    end
                end
            end
        end
    end

    // Receiver: random stalls, and one long hold-off so the block backs up.
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_done && accepted >= 150) begin
                hold_done = 1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if ($urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 50)
                                                  : $urandom_range(0, 2)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(0, 12)) @(negedge aclk);
            end
        end
    end

    // Sender: walks the stimulus list; the checker pops each row on its transfer.
    initial begin
        int gap;
        s_valid = 1'b0;
        s_func = cbvd_pkg::FUNC_BYTE;
        s_packet_byte = '0;
        s_end_of_packet = 1'b0;
        s_table_index = '0;
        s_table_word = '0;
        aresetn = 1'b0;
        build_stimulus();
        luma_tab = '{default: '0};
        chroma_tab = '{default: '0};
        packet_reset();
        cx = 0; cy = 0; start_y = 0; w_cells = 0; h_cells = 0; size_w = 0; size_h = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        while (stim_q.size() > 0) begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : ($urandom_range(0, 9) < 8)
                  ? $urandom_range(1, 3) : $urandom_range(10, 40);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            s_valid <= 1'b1;
            s_func <= stim_q[0].func;
            s_packet_byte <= stim_q[0].pbyte;
            s_end_of_packet <= stim_q[0].eop;
            s_table_index <= stim_q[0].idx;
            s_table_word <= stim_q[0].word;
            do @(posedge aclk); while (!(s_valid && s_ready));
            @(negedge aclk);
        end
        s_valid <= 1'b0;
        while (pending_q.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/cbvd_pkg.sv
hdl/cbvd_ctrl.sv
hdl/cbvd_dp.sv
hdl/cell_block_video_decoder.sv
bench/cell_block_video_decoder_test.sv
